@@ hdl/grs_pkg.sv @@
// Shared types, constants and the 5x7 font ROM for the glyph span renderer.
// No dependencies; every other file of the block imports this package.
package grs_pkg;

  // Character cell geometry.
  localparam int unsigned CELL_W  = 5;
  localparam int unsigned CELL_H  = 7;
  localparam int unsigned MSB_COL = 4;

  // Font ROM size.
  localparam int unsigned FONT_ENTRIES = 41;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned RECT_W     = 70;

  // Row bitmaps of one glyph, row 0 at the top, bit 4 the leftmost column.
  typedef logic [CELL_H-1:0][CELL_W-1:0] glyph_rows_t;

  // Result of a font lookup.
  typedef struct packed {
    logic        hit;
    glyph_rows_t rows;
  } glyph_t;

  // Classified request handed from the front end to the span generator.
  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] fg_colour;
    logic [15:0] bg_colour;
    logic [7:0]  scale;
    logic        known;
    glyph_rows_t rows;
  } cmd_t;

  // One span rectangle, rect_x in the lowest bits.
  typedef struct packed {
    logic [15:0] rect_colour;
    logic [10:0] rect_h;
    logic [10:0] rect_w;
    logic [15:0] rect_y;
    logic [15:0] rect_x;
  } rect_t;

  localparam logic [7:0] FONT_CODES [FONT_ENTRIES] = '{
    8'h20, 8'h2E, 8'h3A, 8'h2D, 8'h2F,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
    8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
    8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A
  };

  localparam logic [4:0] FONT_ROWS [FONT_ENTRIES][CELL_H] = '{
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04},
    '{5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00},
    '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
    '{5'h01, 5'h02, 5'h04, 5'h04, 5'h08, 5'h10, 5'h00},
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
    '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
    '{5'h04, 5'h0A, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
    '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
    '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
    '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C},
    '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
    '{5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11},
    '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
    '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
    '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}
  };

  // Looks a code up among the first 'count' ROM entries; the codes are unique,
  // so at most one entry matches.
  function automatic glyph_t glyph_lookup(input logic [7:0] code, input int count);
    glyph_t res;
    res = '0;
    for (int i = 0; i < int'(FONT_ENTRIES); i++) begin
      if (i < count && FONT_CODES[i] == code) begin
        res.hit = 1'b1;
        for (int r = 0; r < int'(CELL_H); r++) begin
          res.rows[r] = FONT_ROWS[i][r];
        end
      end
    end
    return res;
  endfunction

  // Length of the run of equal bits that starts at column 'col' of a row.
  function automatic logic [2:0] run_length(input logic [CELL_W-1:0] bits,
                                            input logic [2:0] col);
    logic       ref_bit;
    logic       going;
    logic [2:0] n;
    ref_bit = bits[3'(MSB_COL) - col];
    going   = 1'b1;
    n       = '0;
    for (int k = 0; k < int'(CELL_W); k++) begin
      if (3'(k) >= col) begin
        if (going && bits[MSB_COL - k] == ref_bit) begin
          n = n + 3'd1;
        end else begin
          going = 1'b0;
        end
      end
    end
    return n;
  endfunction

endpackage

@@ hdl/grs_front.sv @@
// Front end of the glyph span renderer: unpacks a request, resolves the scale
// and looks the character up in the font ROM. Depends on grs_pkg.
module grs_front
  import grs_pkg::*;
#(
  parameter int GLYPH_COUNT = 41
) (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_DATA_W-1:0] in_data,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd
);

  logic [7:0] char_code;
  logic [7:0] scale_in;
  glyph_t     glyph;

  // Field extraction and font lookup.
  always_comb begin
    char_code = in_data[39:32];
    scale_in  = in_data[79:72];
    glyph     = glyph_lookup(char_code, GLYPH_COUNT);

    cmd.origin_x  = in_data[15:0];
    cmd.origin_y  = in_data[31:16];
    cmd.fg_colour = in_data[55:40];
    cmd.bg_colour = in_data[71:56];
    // A zero scale is drawn as scale one.
    cmd.scale     = (scale_in == 8'd0) ? 8'd1 : scale_in;
    cmd.known     = glyph.hit;
    cmd.rows      = glyph.rows;
  end

  // The queue decides whether a request can be taken.
  assign cmd_valid = in_valid;
  assign in_ready  = cmd_ready;

endmodule

@@ hdl/grs_queue.sv @@
// Two-entry queue of classified requests between the front end and the span
// generator. Depends on grs_pkg for the request type.
module grs_queue
  import grs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic head_valid,
  input  logic pop,
  output cmd_t head
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];
  assign push       = push_valid && push_ready;

  // Pointer and fill-level bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ hdl/grs_back.sv @@
// Span generator: walks the queue head's rows and runs and, when not stalled,
// emits one rectangle per cycle into an output register. Depends on grs_pkg.
module grs_back
  import grs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  cmd_t  head,
  output logic  pop,
  output logic  rect_valid,
  input  logic  rect_ready,
  output rect_t rect,
  output logic  rect_last
);

  logic [2:0]        row;
  logic [2:0]        row_next;
  logic [2:0]        col;
  logic [2:0]        col_next;
  logic [CELL_W-1:0] cur_bits;
  logic              cur_bit;
  logic [2:0]        len;
  logic [2:0]        end_col;
  logic              row_done;
  logic              last;
  logic              emit;
  logic [10:0]       x_off;
  logic [10:0]       y_off;
  rect_t             span;

  // Run detection on the current row.
  always_comb begin
    cur_bits = head.rows[row];
    cur_bit  = cur_bits[3'(MSB_COL) - col];
    len      = run_length(cur_bits, col);
    end_col  = col + len;
    row_done = (end_col == 3'(CELL_W));
    last     = !head.known || (row == 3'(CELL_H - 1) && row_done);
    emit     = head_valid && (!rect_valid || rect_ready);
    pop      = emit && last;
  end

  // Rectangle geometry and colour.
  always_comb begin
    x_off = 11'(col) * 11'(head.scale);
    y_off = 11'(row) * 11'(head.scale);
    span.rect_x = head.origin_x + 16'(x_off);
    span.rect_y = head.origin_y + 16'(y_off);
    if (head.known) begin
      span.rect_w      = 11'(len) * 11'(head.scale);
      span.rect_h      = 11'(head.scale);
      span.rect_colour = cur_bit ? head.fg_colour : head.bg_colour;
    end else begin
      // Unknown code: one background rectangle over the whole cell.
      span.rect_w      = 11'(CELL_W) * 11'(head.scale);
      span.rect_h      = 11'(CELL_H) * 11'(head.scale);
      span.rect_colour = head.bg_colour;
    end
  end

  // Row and column walk.
  always_comb begin
    row_next = row;
    col_next = col;
    if (emit) begin
      priority if (last) begin
        row_next = '0;
        col_next = '0;
      end else if (row_done) begin
        row_next = row + 3'd1;
        col_next = '0;
      end else begin
        col_next = end_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row        <= '0;
      col        <= '0;
      rect_valid <= 1'b0;
    end else begin
      row <= row_next;
      col <= col_next;
      if (emit) begin
        rect_valid <= 1'b1;
      end else if (rect_ready) begin
        rect_valid <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      rect      <= span;
      rect_last <= last;
    end
  end

  a_row_range : assert property (@(posedge clk) disable iff (rst)
    row <= 3'(CELL_H - 1))
    else $error("span generator row beyond the glyph height");

  a_col_range : assert property (@(posedge clk) disable iff (rst)
    col < 3'(CELL_W))
    else $error("span generator column beyond the glyph width");

  a_pop_marks_last : assert property (@(posedge clk) disable iff (rst)
    pop |=> rect_valid && rect_last)
    else $error("request retired without a final span on the output");

  a_blank_at_origin : assert property (@(posedge clk) disable iff (rst)
    (head_valid && !head.known) |-> (row == 3'd0 && col == 3'd0))
    else $error("unknown code seen part-way through a glyph walk");

endmodule

@@ hdl/glyph_span_renderer.sv @@
// Top level of the glyph span renderer: front end, request queue and span
// generator. Depends on grs_pkg, grs_front, grs_queue and grs_back.
//
// Usage: each request on the slave stream names one character to draw; the
// block answers with 1 to 35 rectangles on the master stream, one per run of
// equal pixels in each of the seven glyph rows, tlast on the final one. A code
// that is not in the font gives a single background rectangle of 5s by 7s.
// A request that is taken is first written into the queue; the output register
// is then loaded with the first rectangle from the queue head.
// Throughput: the span generator emits one rectangle per cycle while the
// receiver does not stall; a character has 1 to 35 rectangles (at most
// 7 rows times 5 runs), and the two-entry queue lets the front take new
// requests while a character is being walked.
// Reset empties the queue and the output register; no table needs clearing.
// A stalled receiver holds the current rectangle steady; the generator and
// then the queue fill, after which s_axis_tready falls.
module glyph_span_renderer
  import grs_pkg::*;
#(
  parameter int GLYPH_COUNT = 41
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // origin_x[15:0], origin_y[31:16], char_code[39:32], fg_colour[55:40],
  // bg_colour[71:56], scale[79:72]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // rect_x[15:0], rect_y[31:16], rect_w[42:32], rect_h[53:43],
  // rect_colour[69:54], zeros[71:70]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // last_span
  output logic                  m_axis_tlast
);

  cmd_t  front_cmd;
  logic  front_valid;
  logic  front_ready;
  cmd_t  head;
  logic  head_valid;
  logic  pop;
  rect_t rect;

  // Classification of incoming requests.
  grs_front #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // Decoupling queue.
  grs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  // Span generation and output register.
  grs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rect_valid (m_axis_tvalid),
    .rect_ready (m_axis_tready),
    .rect       (rect),
    .rect_last  (m_axis_tlast)
  );

  // Pack the rectangle, padded to whole bytes.
  assign m_axis_tdata = {(OUT_DATA_W - RECT_W)'(0), rect};

endmodule
